// ===== rtl/rwd_pkg.sv =====
// Shared types and constants for the readout word deframer.
package rwd_pkg;

	// Default structural parameters.
	localparam int CHANNELS_PER_LINK_DEF = 40;
	localparam int MAX_LINKS_DEF         = 64;

	// Fixed field widths of the readout format.
	localparam int WORD_W        = 32;
	localparam int MAP_W         = 40;
	localparam int SEARCH_W      = 64;
	localparam int LEN_W         = 6;
	localparam int LENS_PER_WORD = 4;
	localparam int ROW_ADDR_W    = 4;

	// Special header words.
	localparam logic [WORD_W-1:0] HDR_MULTI_FIRST   = 32'h1111_1111;
	localparam logic [WORD_W-1:0] HDR_MULTI_SECOND  = 32'hbeef_2021;
	localparam logic [WORD_W-1:0] HDR_FOOTER_FIRST  = 32'hd07e_2021;
	localparam logic [WORD_W-1:0] HDR_FOOTER_SECOND = 32'h1234_5678;

	localparam logic [3:0]  BUNCH_VERSION     = 4'd1;
	localparam logic [3:0]  CHIP_REV_RESET    = 4'd3;
	localparam logic [3:0]  CHIP_REV_CM19     = 4'd2;
	localparam logic [5:0]  CM_CHANNEL_V2     = 6'd19;
	localparam logic [5:0]  CM_CHANNEL_OTHER  = 6'd1;
	localparam logic [15:0] ROC_ID_OFFSET     = 16'd256;

	typedef enum logic [1:0] {
		KIND_SAMPLE      = 2'd0,
		KIND_FOOTER      = 2'd1,
		KIND_VERSION_ERR = 2'd2,
		KIND_MAP_OVERRUN = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_HEAD1  = 4'd0,
		PH_HEAD2  = 4'd1,
		PH_WHOLE  = 4'd2,
		PH_SKIP   = 4'd3,
		PH_SHEAD1 = 4'd4,
		PH_SHEAD2 = 4'd5,
		PH_LENS   = 4'd6,
		PH_ROCHDR = 4'd7,
		PH_ROCMAP = 4'd8,
		PH_CHAN   = 4'd9,
		PH_CSUM   = 4'd10,
		PH_IDLE   = 4'd11
	} phase_t;

	// One memory row holds the four link lengths of one length word.
	typedef logic [LENS_PER_WORD-1:0][LEN_W-1:0] len_row_t;

	typedef struct packed {
		logic                  wr_en;
		logic [ROW_ADDR_W-1:0] wr_row;
		len_row_t              wr_data;
		logic                  rd_en;
		logic [ROW_ADDR_W-1:0] rd_row;
	} len_mem_req_t;

endpackage

// ===== rtl/rwd_len_mem.sv =====
// Link length store: one row of four lengths per length word, registered read.
module rwd_len_mem import rwd_pkg::*; #(
	parameter int MAX_LINKS = MAX_LINKS_DEF
) (
	input  logic         clk,
	input  len_mem_req_t req,
	output len_row_t     rd_data
);

	localparam int ROWS  = (MAX_LINKS + LENS_PER_WORD - 1) / LENS_PER_WORD;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int DEPTH = 1 << ROW_W;

	len_row_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_row[ROW_W-1:0]] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data <= mem_q[req.rd_row[ROW_W-1:0]];
		end
	end

endmodule

// ===== rtl/rwd_chan_search.sv =====
// Next set readout map bit at or above a start position (priority encoder).
module rwd_chan_search import rwd_pkg::*; #(
	parameter int CHANNELS_PER_LINK = CHANNELS_PER_LINK_DEF
) (
	input  logic [MAP_W-1:0] map,
	input  logic [6:0]       start,
	output logic             found,
	output logic [5:0]       index
);

	logic [SEARCH_W-1:0] map_ext;

	assign map_ext = SEARCH_W'(map);

	// Scanning downward leaves the lowest qualifying bit in place.
	always_comb begin
		found = 1'b0;
		index = '0;
		for (int i = CHANNELS_PER_LINK - 1; i >= 0; i--) begin
			if (map_ext[i] && (7'(i) >= start)) begin
				found = 1'b1;
				index = 6'(i);
			end
		end
	end

endmodule

// ===== rtl/readout_word_deframer_core.sv =====
// Top level of the readout word deframer: input stage, parser and result register.
//
// The deframer takes one 32-bit readout word per clock while data_ready is high
// and walks the event format: header pairs, the multi-sample event header with
// its skipped sample-length words, bunch headers, packed link lengths, and for
// each link a ROC header, a readout map and its channel words, then the checksum
// word. Each accepted word is captured in an input register and parsed, once
// the result register is free, by a single pass of logic that updates the
// parser state and loads the result register, so a word is accepted every
// clock while results are taken, and its result comes out of the result
// register. A stalled result holds the parser but the input register
// still takes one more word. Channel words are emitted as kind 0 with the FPGA
// index, link index, ROC index and channel number; ROC-header, common-mode and
// checksum channels are dropped. A footer pair yields kind 1, a bunch version
// other than 1 yields kind 2, and a channel word beyond the last set map bit
// yields kind 3; after a footer or a version error the block discards words
// until a word with event_start set. Link lengths are kept in a small memory,
// four to a row, and read in the cycle of the ROC header word; it needs no
// clearing after reset because every length is written before it is read. The
// chip revision register is written through cfg_wr_en and cfg_wr_data and
// should only change while no words are in flight.
module readout_word_deframer_core import rwd_pkg::*; #(
	parameter int CHANNELS_PER_LINK = CHANNELS_PER_LINK_DEF,
	parameter int MAX_LINKS         = MAX_LINKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,

	input  logic        data_valid,
	output logic        data_ready,
	input  logic [31:0] data_word,
	input  logic        event_start,

	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [7:0]  fpga_index,
	output logic [5:0]  link_index,
	output logic [15:0] roc_index,
	output logic [5:0]  channel,
	output logic [31:0] sample
);

	localparam int ROWS = (MAX_LINKS + LENS_PER_WORD - 1) / LENS_PER_WORD;

	// Configuration.
	logic [3:0] chip_rev_q;

	// Input stage.
	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              start_s1;

	// Parser state.
	phase_t            phase_q, phase_d, eff_phase;
	logic [WORD_W-1:0] held_q;
	logic [7:0]        fpga_id_q;
	logic [5:0]        link_count_q;
	logic [5:0]        link_cursor_q;
	logic [15:0]       roc_id_q;
	logic [MAP_W-1:0]  map_q;
	logic [5:0]        channel_cursor_q;
	logic              cursor_started_q;
	logic [5:0]        words_left_q;
	logic [3:0]        skip_left_q;

	// Result register.
	kind_t       kind_q;
	logic [7:0]  fpga_index_q;
	logic [5:0]  link_index_q;
	logic [15:0] roc_index_q;
	logic [5:0]  channel_q;
	logic [31:0] sample_q;

	logic proc;

	// Decoded helpers.
	logic         pair_multi, pair_footer, ver_ok;
	logic [5:0]   hdr_links;
	logic [3:0]   skip_init, skip_dec;
	logic [6:0]   lens_sum;
	logic         lens_done;
	len_mem_req_t mem_req;
	len_row_t     mem_rd_data;
	logic         link_in_range;
	logic [5:0]   len_cur, wl_init, words_dec;
	logic [6:0]   link_inc;
	logic         link_inc_done;
	logic [6:0]   search_start;
	logic         search_found;
	logic [5:0]   search_index;
	logic [5:0]   cm_channel;
	logic         chan_keep;

	// Output decode.
	logic  emit_en, emit_bare;
	kind_t emit_kind;
	logic [5:0] emit_channel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chip_rev_q <= CHIP_REV_RESET;
		end else if (cfg_wr_en) begin
			chip_rev_q <= cfg_wr_data;
		end
	end

	// The parser advances whenever the result register can take what it makes.
	assign proc       = valid_s1 && (!result_valid || result_ready);
	assign data_ready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			word_s1  <= data_word;
			start_s1 <= event_start;
		end
	end

	// A word flagged as an event start restarts the parser on itself.
	assign eff_phase = start_s1 ? PH_HEAD1 : phase_q;

	assign pair_multi  = (held_q == HDR_MULTI_FIRST) && (word_s1 == HDR_MULTI_SECOND);
	assign pair_footer = (held_q == HDR_FOOTER_FIRST) && (word_s1 == HDR_FOOTER_SECOND);
	assign ver_ok      = (held_q[31:28] == BUNCH_VERSION);
	assign hdr_links   = held_q[19:14];

	// Sample-length words carry two lengths each, rounded up.
	assign skip_init = 4'((5'(word_s1[19:16]) + 5'd1) >> 1);
	assign skip_dec  = skip_left_q - 4'd1;

	assign lens_sum  = 7'(link_cursor_q) + 7'(LENS_PER_WORD);
	assign lens_done = (lens_sum >= 7'(link_count_q));

	assign link_in_range = (7'(link_cursor_q) < 7'(MAX_LINKS));
	assign len_cur       = link_in_range ? mem_rd_data[link_cursor_q[1:0]] : '0;
	assign wl_init       = (len_cur >= 6'd2) ? (len_cur - 6'd2) : '0;
	assign words_dec     = words_left_q - 6'd1;

	assign link_inc      = 7'(link_cursor_q) + 7'd1;
	assign link_inc_done = (link_inc >= 7'(link_count_q));

	assign search_start = cursor_started_q ? (7'(channel_cursor_q) + 7'd1) : '0;

	rwd_chan_search #(
		.CHANNELS_PER_LINK(CHANNELS_PER_LINK)
	) u_search (
		.map  (map_q),
		.start(search_start),
		.found(search_found),
		.index(search_index)
	);

	assign cm_channel = (chip_rev_q == CHIP_REV_CM19) ? CM_CHANNEL_V2 : CM_CHANNEL_OTHER;
	assign chan_keep  = (search_index != 6'd0) && (search_index != cm_channel) &&
		(search_index != 6'(CHANNELS_PER_LINK - 1));

	rwd_len_mem #(
		.MAX_LINKS(MAX_LINKS)
	) u_len_mem (
		.clk    (clk),
		.req    (mem_req),
		.rd_data(mem_rd_data)
	);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (eff_phase)
			PH_HEAD1: phase_d = PH_HEAD2;
			PH_HEAD2: begin
				if (pair_multi) begin
					phase_d = PH_WHOLE;
				end else if (pair_footer || !ver_ok) begin
					phase_d = PH_IDLE;
				end else begin
					phase_d = (hdr_links == '0) ? PH_CSUM : PH_LENS;
				end
			end
			PH_WHOLE: phase_d = (skip_init == '0) ? PH_SHEAD1 : PH_SKIP;
			PH_SKIP: phase_d = (skip_dec == '0) ? PH_SHEAD1 : PH_SKIP;
			PH_SHEAD1: phase_d = PH_SHEAD2;
			PH_SHEAD2: begin
				if (!ver_ok) begin
					phase_d = PH_IDLE;
				end else begin
					phase_d = (hdr_links == '0) ? PH_CSUM : PH_LENS;
				end
			end
			PH_LENS: phase_d = lens_done ? PH_ROCHDR : PH_LENS;
			PH_ROCHDR: phase_d = PH_ROCMAP;
			PH_ROCMAP: begin
				if (wl_init == '0) begin
					phase_d = link_inc_done ? PH_CSUM : PH_ROCHDR;
				end else begin
					phase_d = PH_CHAN;
				end
			end
			PH_CHAN: begin
				if (words_dec == '0) begin
					phase_d = link_inc_done ? PH_CSUM : PH_ROCHDR;
				end else begin
					phase_d = PH_CHAN;
				end
			end
			PH_CSUM: phase_d = PH_HEAD1;
			default: phase_d = PH_IDLE;
		endcase
	end

	// Results and memory requests.
	always_comb begin
		emit_en        = 1'b0;
		emit_bare      = 1'b0;
		emit_kind      = KIND_SAMPLE;
		emit_channel   = '0;
		mem_req        = '0;
		mem_req.wr_row = ROW_ADDR_W'(link_cursor_q >> 2);
		mem_req.rd_row = ROW_ADDR_W'(link_cursor_q >> 2);
		mem_req.wr_data = len_row_t'({word_s1[29:24], word_s1[21:16],
			word_s1[13:8], word_s1[5:0]});
		case (eff_phase)
			PH_HEAD2: begin
				if (pair_footer) begin
					emit_en   = 1'b1;
					emit_bare = 1'b1;
					emit_kind = KIND_FOOTER;
				end else if (!pair_multi && !ver_ok) begin
					emit_en   = 1'b1;
					emit_bare = 1'b1;
					emit_kind = KIND_VERSION_ERR;
				end
			end
			PH_SHEAD2: begin
				if (!ver_ok) begin
					emit_en   = 1'b1;
					emit_bare = 1'b1;
					emit_kind = KIND_VERSION_ERR;
				end
			end
			PH_LENS: mem_req.wr_en = (5'(link_cursor_q >> 2) < 5'(ROWS));
			PH_ROCHDR: mem_req.rd_en = 1'b1;
			PH_CHAN: begin
				if (!search_found) begin
					emit_en   = 1'b1;
					emit_kind = KIND_MAP_OVERRUN;
				end else if (chan_keep) begin
					emit_en      = 1'b1;
					emit_kind    = KIND_SAMPLE;
					emit_channel = search_index;
				end
			end
			default: emit_en = 1'b0;
		endcase
		if (!proc) begin
			mem_req.wr_en = 1'b0;
			mem_req.rd_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_HEAD1;
			held_q           <= '0;
			fpga_id_q        <= '0;
			link_count_q     <= '0;
			link_cursor_q    <= '0;
			roc_id_q         <= '0;
			map_q            <= '0;
			channel_cursor_q <= '1;
			cursor_started_q <= 1'b0;
			words_left_q     <= '0;
			skip_left_q      <= '0;
		end else if (proc) begin
			phase_q <= phase_d;
			case (eff_phase)
				PH_HEAD1, PH_SHEAD1: held_q <= word_s1;
				PH_HEAD2, PH_SHEAD2: begin
					if (!(eff_phase == PH_HEAD2 && (pair_multi || pair_footer)) && ver_ok) begin
						fpga_id_q     <= held_q[27:20];
						link_count_q  <= hdr_links;
						link_cursor_q <= '0;
					end
				end
				PH_WHOLE: skip_left_q <= skip_init;
				PH_SKIP: skip_left_q <= skip_dec;
				PH_LENS: link_cursor_q <= lens_done ? '0 : lens_sum[5:0];
				PH_ROCHDR: begin
					roc_id_q <= word_s1[31:16];
					map_q    <= {word_s1[7:0], map_q[31:0]};
				end
				PH_ROCMAP: begin
					map_q            <= {map_q[MAP_W-1:32], word_s1};
					channel_cursor_q <= '1;
					cursor_started_q <= 1'b0;
					words_left_q     <= wl_init;
					if (wl_init == '0) begin
						link_cursor_q <= link_inc_done ? '0 : link_inc[5:0];
					end
				end
				PH_CHAN: begin
					if (search_found) begin
						channel_cursor_q <= search_index;
						cursor_started_q <= 1'b1;
					end
					words_left_q <= words_dec;
					if (words_dec == '0) begin
						link_cursor_q <= link_inc_done ? '0 : link_inc[5:0];
					end
				end
				default: held_q <= held_q;
			endcase
		end
	end

	// Result register: loads when the parser makes a result, empties when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (proc) begin
			result_valid <= emit_en;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit_en) begin
			kind_q    <= emit_kind;
			channel_q <= emit_channel;
			if (emit_bare) begin
				fpga_index_q <= '0;
				link_index_q <= '0;
				roc_index_q  <= '0;
				sample_q     <= '0;
			end else begin
				fpga_index_q <= fpga_id_q - 8'd1;
				link_index_q <= link_cursor_q;
				roc_index_q  <= roc_id_q - ROC_ID_OFFSET;
				sample_q     <= word_s1;
			end
		end
	end

	assign kind       = kind_q;
	assign fpga_index = fpga_index_q;
	assign link_index = link_index_q;
	assign roc_index  = roc_index_q;
	assign channel    = channel_q;
	assign sample     = sample_q;

	// A word held in the input stage waits intact until the parser takes it.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !proc |=> valid_s1 && $stable(word_s1))
		else $error("input stage lost or changed a waiting word");

	a_chan_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CHAN |-> words_left_q != '0)
		else $error("channel phase with no words left");

	a_skip_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_left_q != '0)
		else $error("skip phase with no words left");

	a_link_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ROCHDR || phase_q == PH_ROCMAP || phase_q == PH_CHAN)
		|-> link_cursor_q < link_count_q)
		else $error("link cursor beyond link count inside a link");

	a_footer_bare: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind_q == KIND_FOOTER || kind_q == KIND_VERSION_ERR)
		|-> fpga_index_q == '0 && roc_index_q == '0 && sample_q == '0 && channel_q == '0)
		else $error("footer or version error carries nonzero fields");

endmodule

// ===== test/readout_word_deframer_core_test.sv =====
// Self-checking testbench for the readout word deframer core.
module readout_word_deframer_core_test import rwd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CHANNELS      = CHANNELS_PER_LINK_DEF;
	localparam int LINK_SLOTS    = MAX_LINKS_DEF;
	localparam int RANDOM_WORDS  = 650;
	localparam int MAX_WAIT      = 16;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;
	localparam int LONG_HOLD_AT  = 30;
	localparam int CYCLE_LIMIT   = 250000;
	localparam int REPORT_LIMIT  = 10;

	// One result word as the block presents it on its output ports.
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  fpga;
		logic [5:0]  link;
		logic [15:0] roc;
		logic [5:0]  chan;
		logic [31:0] sample;
	} deframe_result_t;

	// One input word together with its event_start flag.
	typedef struct packed {
		logic [31:0] word;
		logic        start;
	} frame_word_t;

	// One row of the directed script. Where typed is set, the expected result is
	// written into the row; otherwise the parser model decides.
	typedef struct packed {
		logic            start;
		logic [31:0]     word;
		bit              typed;
		deframe_result_t want;
	} script_row_t;

	localparam deframe_result_t NO_RESULT =
		'{KIND_SAMPLE, 8'h00, 6'h00, 16'h0000, 6'h00, 32'h0};
	localparam deframe_result_t FOOTER_SEEN =
		'{KIND_FOOTER, 8'h00, 6'h00, 16'h0000, 6'h00, 32'h0};
	localparam deframe_result_t VERSION_ERROR =
		'{KIND_VERSION_ERR, 8'h00, 6'h00, 16'h0000, 6'h00, 32'h0};

	// The directed script walks the special cases in order. A footer right after
	// event_start gives a footer result and the parser then ignores words. A
	// bunch version of zero gives the version error. A bunch with FPGA id zero
	// and no links goes straight to its checksum word. A multi-sample header
	// whose sample-length field rounds to zero skipped words follows without an
	// event_start, since the checksum returns the parser to the first header
	// word. Its bunch has FPGA id 255 and two links: a short link of length one,
	// then a link whose map holds channels 0, 1, 19 and 39, so that the
	// ROC-header channel, the common-mode channel and the CRC channel are
	// dropped, channel 19 is emitted, and the fifth channel word runs off the
	// end of the map.
	localparam int SCRIPT_ROWS = 24;
	localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
		'{1'b1, HDR_FOOTER_FIRST,  1'b0, NO_RESULT},
		'{1'b0, HDR_FOOTER_SECOND, 1'b1, FOOTER_SEEN},
		'{1'b0, 32'hffff_ffff,     1'b0, NO_RESULT},
		'{1'b1, 32'h0000_0000,     1'b0, NO_RESULT},
		'{1'b0, 32'hffff_ffff,     1'b1, VERSION_ERROR},
		'{1'b1, 32'h1000_0000,     1'b0, NO_RESULT},
		'{1'b0, 32'h0000_0000,     1'b0, NO_RESULT},
		'{1'b0, 32'hffff_ffff,     1'b0, NO_RESULT},
		'{1'b0, HDR_MULTI_FIRST,   1'b0, NO_RESULT},
		'{1'b0, HDR_MULTI_SECOND,  1'b0, NO_RESULT},
		'{1'b0, 32'hfff0_ffff,     1'b0, NO_RESULT},
		'{1'b0, 32'h1ff0_8000,     1'b0, NO_RESULT},
		'{1'b0, 32'habcd_0123,     1'b0, NO_RESULT},
		'{1'b0, 32'hffff_c7c1,     1'b0, NO_RESULT},
		'{1'b0, 32'h0100_0000,     1'b0, NO_RESULT},
		'{1'b0, 32'h0000_0000,     1'b0, NO_RESULT},
		'{1'b0, 32'h00ff_0080,     1'b0, NO_RESULT},
		'{1'b0, 32'h0008_0003,     1'b0, NO_RESULT},
		'{1'b0, 32'hffff_ffff,     1'b0, NO_RESULT},
		'{1'b0, 32'h0000_0000,     1'b0, NO_RESULT},
		'{1'b0, 32'ha5a5_a5a5,     1'b0, NO_RESULT},
		'{1'b0, 32'h5a5a_5a5a,     1'b0, NO_RESULT},
		'{1'b0, 32'h1234_5678,     1'b0, NO_RESULT},
		'{1'b0, 32'h0000_0000,     1'b0, NO_RESULT}
	};

	// The random part runs in phases, each under its own chip revision. The
	// common-mode setting comes twice, the extremes 0 and 15 once each.
	localparam logic [3:0] ROC_SETTINGS [6] = '{
		CHIP_REV_CM19, 4'd0, 4'd15, CHIP_REV_RESET, CHIP_REV_CM19, 4'd1
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [3:0]  cfg_wr_data = 4'd0;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic [31:0] data_word = 32'h0;
	logic        event_start = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  fpga_index;
	logic [5:0]  link_index;
	logic [15:0] roc_index;
	logic [5:0]  channel;
	logic [31:0] sample;

	readout_word_deframer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.data_valid   (data_valid),
		.data_ready   (data_ready),
		.data_word    (data_word),
		.event_start  (event_start),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.fpga_index   (fpga_index),
		.link_index   (link_index),
		.roc_index    (roc_index),
		.channel      (channel),
		.sample       (sample)
	);

	always #2 clk = ~clk;

	// Results the parser model has predicted and the block has not yet delivered.
	deframe_result_t expected_q [$];
	// Words of the event being built, waiting to be sent.
	frame_word_t frame_q [$];

	int mismatches = 0;
	int cycle_count = 0;
	int parsed_words = 0;
	int send_count = 0;
	bit send_calm = 1'b0;

	// Parser model state. It follows the block word by word, one accepted word
	// at a time, in the same phases as the block's own parser.
	logic [3:0]  chip_rev_q = CHIP_REV_RESET;
	phase_t      parse_phase = PH_HEAD1;
	logic [31:0] held_word = 32'h0;
	logic [7:0]  fpga_id = 8'h0;
	int          link_count = 0;
	logic [5:0]  link_len [LINK_SLOTS];
	int          link_cursor = 0;
	logic [15:0] roc_id = 16'h0;
	logic [39:0] read_map = 40'h0;
	int          chan_cursor = 63;
	bit          chan_started = 1'b0;
	int          words_left = 0;
	int          skip_left = 0;

	// Builds a channel-word result from the current link context.
	function automatic deframe_result_t channel_result(input kind_t k, input int ch,
			input logic [31:0] w);
		deframe_result_t r;
		r.kind   = k;
		r.fpga   = fpga_id - 8'd1;
		r.link   = 6'(link_cursor);
		r.roc    = roc_id - ROC_ID_OFFSET;
		r.chan   = 6'(ch);
		r.sample = w;
		return r;
	endfunction

	// The held word is the first word of a bunch header. A version other than
	// one is an error and the parser goes idle until the next event_start.
	function automatic bit open_bunch(output deframe_result_t r);
		r = NO_RESULT;
		if (held_word[31:28] != BUNCH_VERSION) begin
			parse_phase = PH_IDLE;
			r = VERSION_ERROR;
			return 1'b1;
		end
		fpga_id = held_word[27:20];
		link_count = int'(held_word[19:14]);
		link_cursor = 0;
		parse_phase = (link_count == 0) ? PH_CSUM : PH_LENS;
		return 1'b0;
	endfunction

	// Moves to the next link, or to the checksum word after the last one.
	function automatic void advance_link();
		link_cursor++;
		if (link_cursor >= link_count) begin
			link_cursor = 0;
			parse_phase = PH_CSUM;
		end else begin
			parse_phase = PH_ROCHDR;
		end
	endfunction

	// Steps the parser model by one accepted word; returns 1 with the result in
	// r when the word causes one.
	function automatic bit deframe_word(input logic [31:0] w, input logic s,
			output deframe_result_t r);
		int i;
		int cm;
		int len;
		bit made;
		r = NO_RESULT;
		made = 1'b0;
		if (s) parse_phase = PH_HEAD1;
		case (parse_phase)
		PH_HEAD1: begin
			held_word = w;
			parse_phase = PH_HEAD2;
		end
		PH_HEAD2: begin
			if (held_word == HDR_MULTI_FIRST && w == HDR_MULTI_SECOND) begin
				parse_phase = PH_WHOLE;
			end else if (held_word == HDR_FOOTER_FIRST && w == HDR_FOOTER_SECOND) begin
				parse_phase = PH_IDLE;
				r = FOOTER_SEEN;
				made = 1'b1;
			end else begin
				made = open_bunch(r);
			end
		end
		PH_WHOLE: begin
			// The sample-length words pack two lengths each, rounded up.
			skip_left = (int'(w[19:16]) + 1) / 2;
			parse_phase = (skip_left == 0) ? PH_SHEAD1 : PH_SKIP;
		end
		PH_SKIP: begin
			skip_left--;
			if (skip_left == 0) parse_phase = PH_SHEAD1;
		end
		PH_SHEAD1: begin
			held_word = w;
			parse_phase = PH_SHEAD2;
		end
		PH_SHEAD2: begin
			made = open_bunch(r);
		end
		PH_LENS: begin
			for (i = 0; i < LENS_PER_WORD; i++) begin
				if (link_cursor + i < link_count) link_len[link_cursor + i] = w[8 * i +: 6];
			end
			link_cursor += LENS_PER_WORD;
			if (link_cursor >= link_count) begin
				link_cursor = 0;
				parse_phase = PH_ROCHDR;
			end
		end
		PH_ROCHDR: begin
			roc_id = w[31:16];
			read_map = {w[7:0], 32'h0};
			parse_phase = PH_ROCMAP;
		end
		PH_ROCMAP: begin
			read_map[31:0] = w;
			chan_cursor = 63;
			chan_started = 1'b0;
			len = int'(link_len[link_cursor]);
			words_left = (len >= 2) ? len - 2 : 0;
			if (words_left == 0) advance_link();
			else parse_phase = PH_CHAN;
		end
		PH_CHAN: begin
			// Next set map bit after the last channel taken in this link.
			i = chan_started ? chan_cursor + 1 : 0;
			while (i < CHANNELS && !read_map[i]) i++;
			if (i >= CHANNELS) begin
				r = channel_result(KIND_MAP_OVERRUN, 0, w);
				made = 1'b1;
			end else begin
				chan_cursor = i;
				chan_started = 1'b1;
				cm = (chip_rev_q == CHIP_REV_CM19) ? int'(CM_CHANNEL_V2)
					: int'(CM_CHANNEL_OTHER);
				if (i != 0 && i != cm && i != CHANNELS - 1) begin
					r = channel_result(KIND_SAMPLE, i, w);
					made = 1'b1;
				end
			end
			words_left--;
			if (words_left == 0) advance_link();
		end
		PH_CSUM: begin
			parse_phase = PH_HEAD1;
		end
		default: begin
			parse_phase = PH_IDLE;
		end
		endcase
		return made;
	endfunction

	function automatic void queue_word(input logic [31:0] w, input logic s);
		frame_word_t fw;
		fw.word = w;
		fw.start = s;
		frame_q.push_back(fw);
	endfunction

	// Appends one bunch: header pair, packed link lengths, per link a ROC header,
	// a map word and its channel words, then the checksum. Most bunches have few
	// links and short lengths; now and then one has many links or a long link.
	// A bad bunch stops after its header pair and a little trailing junk.
	function automatic void add_bunch(input bit good);
		int pick;
		int links;
		int len;
		int row;
		int k;
		int drawn [LINK_SLOTS];
		logic [3:0]  bad_version;
		logic [31:0] head;
		logic [31:0] lens_word;
		logic [31:0] roc_head;
		logic [39:0] map_bits;
		pick = int'($urandom_range(0, 19));
		if (pick == 0) links = 0;
		else if (pick < 15) links = int'($urandom_range(1, 3));
		else if (pick < 19) links = int'($urandom_range(4, 8));
		else links = int'($urandom_range(9, 63));
		bad_version = 4'($urandom_range(0, 14));
		if (bad_version >= BUNCH_VERSION) bad_version = bad_version + 4'd1;
		head = $urandom();
		head[31:28] = good ? BUNCH_VERSION : bad_version;
		head[19:14] = 6'(links);
		queue_word(head, 1'b0);
		queue_word($urandom(), 1'b0);
		if (!good) begin
			repeat ($urandom_range(0, 3)) queue_word($urandom(), 1'b0);
			return;
		end
		for (row = 0; row < (links + LENS_PER_WORD - 1) / LENS_PER_WORD; row++) begin
			lens_word = $urandom();
			for (k = 0; k < LENS_PER_WORD; k++) begin
				if (row * LENS_PER_WORD + k < links) begin
					if (links > 8) len = int'($urandom_range(0, 4));
					else if ($urandom_range(0, 15) == 0) len = int'($urandom_range(11, 63));
					else len = int'($urandom_range(0, 10));
					lens_word[8 * k +: 6] = 6'(len);
					drawn[row * LENS_PER_WORD + k] = len;
				end
			end
			queue_word(lens_word, 1'b0);
		end
		for (k = 0; k < links; k++) begin
			case ($urandom_range(0, 5))
			0: map_bits = '1;
			1: map_bits = '0;
			2: map_bits = 40'({$urandom(), $urandom()}) & 40'({$urandom(), $urandom()})
				& 40'({$urandom(), $urandom()});
			default: map_bits = 40'({$urandom(), $urandom()});
			endcase
			roc_head = $urandom();
			if ($urandom_range(0, 7) == 0) roc_head[31:16] = ROC_ID_OFFSET;
			roc_head[7:0] = map_bits[39:32];
			queue_word(roc_head, 1'b0);
			queue_word(map_bits[31:0], 1'b0);
			for (len = 2; len < drawn[k]; len++) queue_word($urandom(), 1'b0);
		end
		queue_word($urandom(), 1'b0);
	endfunction

	// Appends one event. Most are well formed, plain or multi-sample, usually
	// closed by a footer. The rest are noise, bunches with a bad version, or
	// well-formed events cut short so that the next event_start lands mid-parse.
	function automatic void add_event();
		int pick;
		int base;
		int keep;
		bit multi;
		logic [31:0] whole;
		frame_word_t fw;
		pick = int'($urandom_range(0, 9));
		base = frame_q.size();
		if (pick == 0) begin
			repeat ($urandom_range(1, 6)) queue_word($urandom(), $urandom_range(0, 3) == 0);
			return;
		end
		if (pick == 1) begin
			add_bunch(1'b0);
		end else begin
			multi = (pick >= 6 && pick <= 8) || (pick == 9 && $urandom_range(0, 1) == 1);
			if (multi) begin
				queue_word(HDR_MULTI_FIRST, 1'b0);
				queue_word(HDR_MULTI_SECOND, 1'b0);
				whole = $urandom();
				queue_word(whole, 1'b0);
				repeat ((int'(whole[19:16]) + 1) / 2) queue_word($urandom(), 1'b0);
			end
			add_bunch(!multi || $urandom_range(0, 7) != 0);
			if ($urandom_range(0, 9) < 3) add_bunch(1'b1);
			if ($urandom_range(0, 9) < 8) begin
				queue_word(HDR_FOOTER_FIRST, 1'b0);
				queue_word(HDR_FOOTER_SECOND, 1'b0);
			end
			if ($urandom_range(0, 9) < 3) begin
				repeat ($urandom_range(1, 3)) queue_word($urandom(), 1'b0);
			end
			if (pick == 9) begin
				keep = base + int'($urandom_range(1, frame_q.size() - base));
				while (frame_q.size() > keep) void'(frame_q.pop_back());
			end
		end
		fw = frame_q[base];
		fw.start = 1'b1;
		frame_q[base] = fw;
	endfunction

	// Offers one word after a random gap and waits until the block takes it. The
	// valid line is only lowered when a gap follows, so back-to-back words keep
	// it high. Every so often the sender switches between gapped and gap-free
	// stretches.
	task automatic send_word(input logic [31:0] w, input logic s, output bit made,
			output deframe_result_t r);
		int pause;
		if (send_count % 48 == 0) send_calm = $urandom_range(0, 2) == 0;
		send_count++;
		pause = send_calm ? 0 : int'($urandom_range(0, MAX_WAIT));
		if (pause > 0) begin
			data_valid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_word <= w;
		event_start <= s;
		do @(posedge clk); while (!data_ready);
		// Words dropped while the parser sits idle do not count toward the goal.
		if (s || parse_phase != PH_IDLE) parsed_words++;
		made = deframe_word(w, s, r);
	endtask

	// Stops offering words until every predicted result has come out, then lets
	// the pipeline settle for as long as extra asks.
	task automatic hold_sender(input int extra);
		data_valid <= 1'b0;
		do @(posedge clk); while (expected_q.size() > 0);
		repeat (extra) @(posedge clk);
	endtask

	// Writes the chip revision; only called while the block holds no words.
	task automatic write_chip_rev(input logic [3:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		chip_rev_q = v;
	endtask

	// Result side. Ready is raised after a random stall per word and held until
	// a word arrives. Once, after a few dozen results, the receiver holds off
	// for a long stretch so that the block backs up and stalls its input.
	initial begin : receiver
		int hold;
		int taken;
		bit calm;
		taken = 0;
		calm = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken % 40 == 0) calm = $urandom_range(0, 2) == 0;
			hold = calm ? 0 : int'($urandom_range(0, MAX_WAIT));
			if (taken == LONG_HOLD_AT) hold = LONG_HOLD;
			if (hold > 0) begin
				result_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			taken++;
		end
	end

	// Every accepted result is compared, field by field, with the oldest
	// prediction still waiting.
	always @(posedge clk) begin : result_check
		deframe_result_t got;
		deframe_result_t want;
		if (arst_n && result_valid && result_ready) begin
			got.kind   = kind_t'(kind);
			got.fpga   = fpga_index;
			got.link   = link_index;
			got.roc    = roc_index;
			got.chan   = channel;
			got.sample = sample;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("unexpected result: kind %0d fpga %h link %0d",
						got.kind, got.fpga, got.link);
					$display("  roc %h chan %0d sample %h",
						got.roc, got.chan, got.sample);
				end
			end else begin
				want = expected_q.pop_front();
				if (got.kind !== want.kind || got.fpga !== want.fpga
						|| got.link !== want.link || got.roc !== want.roc
						|| got.chan !== want.chan || got.sample !== want.sample) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("mismatch: expected kind %0d fpga %h link %0d roc %h chan %0d sample %h",
							want.kind, want.fpga, want.link, want.roc, want.chan,
							want.sample);
						$display("  got kind %0d fpga %h link %0d roc %h chan %0d sample %h",
							got.kind, got.fpga, got.link, got.roc, got.chan,
							got.sample);
					end
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		bit made;
		deframe_result_t want;
		frame_word_t fw;
		int goal;
		bit paused;
		foreach (link_len[i]) link_len[i] = 6'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script under the reset value of the chip revision.
		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			send_word(SCRIPT[i].word, SCRIPT[i].start, made, want);
			if (SCRIPT[i].typed) expected_q.push_back(SCRIPT[i].want);
			else if (made) expected_q.push_back(want);
		end

		// Random events, one chip revision per phase. The register is only
		// written once the block has drained. An event still queued when a phase
		// reaches its goal is cut short; the next phase opens with event_start.
		for (int p = 0; p < 6; p++) begin
			hold_sender(SETTLE_CYCLES);
			write_chip_rev(ROC_SETTINGS[p]);
			goal = parsed_words + RANDOM_WORDS / 6;
			paused = 1'b0;
			while (parsed_words < goal) begin
				add_event();
				while (frame_q.size() > 0 && parsed_words < goal) begin
					fw = frame_q.pop_front();
					send_word(fw.word, fw.start, made, want);
					if (made) expected_q.push_back(want);
				end
				// Midway through one phase the sender waits for the block to empty.
				if (p == 2 && !paused && parsed_words >= goal - RANDOM_WORDS / 12) begin
					paused = 1'b1;
					hold_sender(0);
				end
			end
			frame_q.delete();
		end

		hold_sender(SETTLE_CYCLES);
		if (mismatches == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

endmodule
